// File: design/gaussian_downsample_by_three_unit_defines.svh
// Assertion macros for the gaussian downsample unit.
`ifndef GAUSSIAN_DOWNSAMPLE_BY_THREE_UNIT_DEFINES_SVH
`define GAUSSIAN_DOWNSAMPLE_BY_THREE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/gds3_pkg.sv
// Shared constants and types for the gaussian downsample unit.
`timescale 1ns / 1ps

package gds3_pkg;

    localparam int OUT_WIDTH_BITS   = 11;
    localparam int OUT_HEIGHT_BITS  = 13;
    localparam int CFG_DATA_BITS    = 13;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int MAX_OUT_HEIGHT   = 4096;
    localparam int ROW_BITS         = 14;
    localparam int RESET_OUT_WIDTH  = 640;
    localparam int RESET_OUT_HEIGHT = 480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OUT_WIDTH  = 1'b0,
        CFG_OUT_HEIGHT = 1'b1
    } t_cfg_index;

    typedef logic [1:0] t_phase;

    localparam t_phase PHASE_ZERO   = 2'd0;
    localparam t_phase PHASE_CENTER = 2'd1;
    localparam t_phase PHASE_LAST   = 2'd2;

endpackage

// File: design/gaussian_downsample_by_three_unit.sv
// 3x3 Gaussian filter and 3:1 downsample of a supersampled RGB pixel stream.
// One super pixel per clock is accepted back to back while the result side
// keeps up. A result left waiting in the output register holds the input off
// once the next emitting item reaches stage 1, until that result is taken.
// Stage 0 tracks the raster position and reads both line buffers at the
// current column. Stage 1 forms the filtered pixel and writes the line
// buffers back when it advances, with a bypass when both touch the same column.
// The result register loads when stage 1 advances with an emitting item, so
// o_valid rises only once the item has left stage 1. o_ready is low during
// reset. The line buffers (3*MAX_OUT_WIDTH pixels each) are not cleared after
// reset, so the first two super rows of a frame must be supplied before rows
// below them are filtered.
`timescale 1ns / 1ps
`include "gaussian_downsample_by_three_unit_defines.svh"

module gaussian_downsample_by_three_unit
    import gds3_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int CHANNEL_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // super pixel input
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [CHANNEL_BITS-1:0]   i_red_in,
    input  logic [CHANNEL_BITS-1:0]   i_green_in,
    input  logic [CHANNEL_BITS-1:0]   i_blue_in,
    input  logic                      i_frame_start,
    // filtered output
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CHANNEL_BITS-1:0]   o_red_out,
    output logic [CHANNEL_BITS-1:0]   o_green_out,
    output logic [CHANNEL_BITS-1:0]   o_blue_out,
    output logic                      o_row_end,
    output logic                      o_frame_end
);

    localparam int LINE_DEPTH = 3 * MAX_OUT_WIDTH;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(LINE_DEPTH + 1);
    localparam int SUM_W      = CHANNEL_BITS + 4;
    localparam int CSUM_W     = CHANNEL_BITS + 2;

    typedef logic [2:0][CHANNEL_BITS-1:0] t_pixel;

    // 3 * clamp(w, 1, MAX_OUT_WIDTH)
    function automatic logic [COL_W-1:0] f_cols(input logic [OUT_WIDTH_BITS-1:0] w);
        logic [31:0] wd;
        wd = 32'(w);
        if (wd == 32'd0) begin
            wd = 32'd1;
        end else if (wd > 32'(MAX_OUT_WIDTH)) begin
            wd = 32'(MAX_OUT_WIDTH);
        end
        return COL_W'(wd + (wd << 1));
    endfunction

    // 3 * clamp(h, 1, MAX_OUT_HEIGHT)
    function automatic logic [ROW_BITS-1:0] f_rows(input logic [OUT_HEIGHT_BITS-1:0] h);
        logic [31:0] ht;
        ht = 32'(h);
        if (ht == 32'd0) begin
            ht = 32'd1;
        end else if (ht > 32'(MAX_OUT_HEIGHT)) begin
            ht = 32'(MAX_OUT_HEIGHT);
        end
        return ROW_BITS'(ht + (ht << 1));
    endfunction

    function automatic logic [CSUM_W-1:0] f_col_sum(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b,
        input logic [CHANNEL_BITS-1:0] c
    );
        return CSUM_W'(a) + (CSUM_W'(b) << 1) + CSUM_W'(c);
    endfunction

    function automatic t_phase f_phase_inc(input t_phase ph);
        return (ph == PHASE_LAST) ? PHASE_ZERO : t_phase'(ph + 2'd1);
    endfunction

    // ---------------- configuration ----------------
    logic [COL_W-1:0]    r_cols;
    logic [ROW_BITS-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= f_cols(OUT_WIDTH_BITS'(RESET_OUT_WIDTH));
            r_rows <= f_rows(OUT_HEIGHT_BITS'(RESET_OUT_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_OUT_WIDTH:  r_cols <= f_cols(i_cfg_wdata[OUT_WIDTH_BITS-1:0]);
                CFG_OUT_HEIGHT: r_rows <= f_rows(i_cfg_wdata[OUT_HEIGHT_BITS-1:0]);
            endcase
        end
    end

    // ---------------- stage 0: position and line buffer read ----------------
    logic [COL_W-1:0]    r_col;
    logic [ROW_BITS-1:0] r_row;
    t_phase              r_col_ph, r_row_ph;

    logic                in_accept;
    logic [COL_W-1:0]    col_base, c0, c1;
    logic [ROW_BITS-1:0] row_base, row_inc, row_pre, r0, r1;
    t_phase              col_base_ph, row_base_ph, row_pre_ph, cph0, rph0;
    logic                col_wrap0, row_wrap0, col_wrap1;
    logic [COL_W-1:0]    n_col;
    logic [ROW_BITS-1:0] n_row;
    t_phase              n_col_ph, n_row_ph;
    logic                emit0, row_end0, frame_end0;

    always_comb begin
        col_base    = i_frame_start ? '0 : r_col;
        row_base    = i_frame_start ? '0 : r_row;
        col_base_ph = i_frame_start ? PHASE_ZERO : r_col_ph;
        row_base_ph = i_frame_start ? PHASE_ZERO : r_row_ph;

        // a stale column past the row length starts the next row
        col_wrap0  = (col_base >= r_cols);
        c0         = col_wrap0 ? '0 : col_base;
        cph0       = col_wrap0 ? PHASE_ZERO : col_base_ph;
        row_inc    = row_base + ROW_BITS'(1);
        row_pre    = col_wrap0 ? row_inc : row_base;
        row_pre_ph = col_wrap0 ? f_phase_inc(row_base_ph) : row_base_ph;
        row_wrap0  = (row_pre >= r_rows);
        r0         = row_wrap0 ? '0 : row_pre;
        rph0       = row_wrap0 ? PHASE_ZERO : row_pre_ph;

        // position of the following item
        c1        = c0 + COL_W'(1);
        r1        = r0 + ROW_BITS'(1);
        col_wrap1 = (c1 >= r_cols);
        if (col_wrap1) begin
            n_col    = '0;
            n_col_ph = PHASE_ZERO;
            if (r1 >= r_rows) begin
                n_row    = '0;
                n_row_ph = PHASE_ZERO;
            end else begin
                n_row    = r1;
                n_row_ph = f_phase_inc(rph0);
            end
        end else begin
            n_col    = c1;
            n_col_ph = f_phase_inc(cph0);
            n_row    = r0;
            n_row_ph = rph0;
        end

        emit0      = (cph0 == PHASE_CENTER) && (rph0 == PHASE_CENTER);
        row_end0   = (c0 == r_cols - COL_W'(2));
        frame_end0 = row_end0 && (r0 == r_rows - ROW_BITS'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= PHASE_ZERO;
            r_row_ph <= PHASE_ZERO;
        end else if (in_accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

    // ---------------- line buffers ----------------
    t_pixel r_line_above_mem       [LINE_DEPTH];
    t_pixel r_line_above_above_mem [LINE_DEPTH];
    t_pixel r_la_q, r_laa_q;

    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = c0[ADDR_W-1:0];

    // ---------------- stage 1 registers ----------------
    logic              r_s1_valid;
    t_pixel            r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_emit, r_s1_left_edge, r_s1_row_ge1, r_s1_row_ge2;
    logic              r_s1_row_end, r_s1_frame_end;
    logic              r_fwd;
    t_pixel            r_fwd_la, r_fwd_laa;

    logic   out_free, s1_adv;
    t_pixel in_pix, la_eff, laa_eff;

    assign in_pix   = {i_blue_in, i_green_in, i_red_in};
    assign out_free = !o_valid || i_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_emit || out_free);
    assign o_ready  = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_accept = i_valid && o_ready;

    // bypass covers a write to the column read in the same cycle
    assign la_eff  = r_fwd ? r_fwd_la  : r_la_q;
    assign laa_eff = r_fwd ? r_fwd_laa : r_laa_q;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_above_above_mem[r_s1_addr] <= la_eff;
            r_line_above_mem[r_s1_addr]       <= r_s1_pix;
        end
        if (in_accept) begin
            r_la_q  <= r_line_above_mem[rd_addr];
            r_laa_q <= r_line_above_above_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_adv && (r_s1_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix       <= in_pix;
            r_s1_addr      <= rd_addr;
            r_s1_emit      <= emit0;
            r_s1_left_edge <= (c0 == COL_W'(1));
            r_s1_row_ge1   <= (r0 != '0);
            r_s1_row_ge2   <= (r0 > ROW_BITS'(1));
            r_s1_row_end   <= row_end0;
            r_s1_frame_end <= frame_end0;
            r_fwd_la       <= r_s1_pix;
            r_fwd_laa      <= la_eff;
        end
    end

    // ---------------- stage 1: window and filter ----------------
    t_pixel r_win [6];   // [0..2] column c-2, [3..5] column c-1; top, middle, bottom
    t_pixel now_top, now_mid;
    t_pixel left_top, left_mid, left_bot;
    t_pixel filt;

    always_comb begin
        logic [CSUM_W-1:0] sum_l, sum_m, sum_n;
        logic [SUM_W-1:0]  total;
        now_mid  = r_s1_row_ge1 ? la_eff : r_s1_pix;
        now_top  = r_s1_row_ge2 ? laa_eff : now_mid;
        left_top = r_s1_left_edge ? r_win[3] : r_win[0];
        left_mid = r_s1_left_edge ? r_win[4] : r_win[1];
        left_bot = r_s1_left_edge ? r_win[5] : r_win[2];
        for (int k = 0; k < 3; k++) begin
            sum_l   = f_col_sum(left_top[k], left_mid[k], left_bot[k]);
            sum_m   = f_col_sum(r_win[3][k], r_win[4][k], r_win[5][k]);
            sum_n   = f_col_sum(now_top[k], now_mid[k], r_s1_pix[k]);
            total   = SUM_W'(sum_l) + (SUM_W'(sum_m) << 1) + SUM_W'(sum_n);
            filt[k] = total[SUM_W-1:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= now_top;
            r_win[4] <= now_mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // ---------------- output register ----------------
    logic   r_out_valid;
    t_pixel r_out_pix;
    logic   r_out_row_end, r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_pix       <= filt;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out_pix[0];
    assign o_green_out = r_out_pix[1];
    assign o_blue_out  = r_out_pix[2];
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_frame_end_on_row_end, i_clk, i_rst_n, r_out_valid && r_out_frame_end, r_out_row_end)
    `ASSERT_IMPLIES(a_no_accept_when_blocked, i_clk, i_rst_n, r_s1_valid && r_s1_emit && r_out_valid && !i_ready, !o_ready)
    `ASSERT_IMPLIES(a_col_phase_at_row_start, i_clk, i_rst_n, r_col == '0, r_col_ph == PHASE_ZERO)
    `ASSERT_IMPLIES(a_bypass_needs_stage1, i_clk, i_rst_n, r_fwd, r_s1_valid)

endmodule
